// ===== rtl/crc8fp_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fp_pkg: shared types and functions of the CRC-8 frame parser
// Parser state codes, status codes, register indexes, the result word layout
// and the byte-wide CRC-8 (poly 0x07) update.
// ----------------------------------------------------------------------------
package crc8fp_pkg;

   localparam int ByteWidth = 8;
   localparam logic [7:0] CrcPoly = 8'h07;
   localparam logic [7:0] CrcInit = 8'h00;
   localparam logic [7:0] CrcTopBit = 8'h80;

   // parser state, one-hot
   typedef enum logic [4:0] {
      ST_HUNT    = 5'b00001,
      ST_TYPE    = 5'b00010,
      ST_LEN     = 5'b00100,
      ST_PAYLOAD = 5'b01000,
      ST_CRC     = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      STATUS_INCOMPLETE = 2'd0,
      STATUS_COMPLETE   = 2'd1,
      STATUS_ERROR      = 2'd2
   } status_type;

   typedef enum logic {
      CSR_START_BYTE = 1'b0,
      CSR_MAX_LEN    = 1'b1
   } csr_index_type;

   typedef struct packed {
      status_type      status;
      logic            payload_valid;
      logic [7:0]      payload_byte;
      logic            payload_last;
      logic [7:0]      frame_type;
      logic [7:0]      frame_len;
   } result_type;

   // one byte through the CRC-8 shift register, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < ByteWidth; k++) begin
         if ((v & CrcTopBit) != 8'h00) begin
            v = {v[6:0], 1'b0} ^ CrcPoly;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ===== rtl/crc8_frame_parser.sv =====
// ----------------------------------------------------------------------------
// crc8_frame_parser: CRC-8 length-prefixed frame parser
// Hunts for the start byte, then reads type, length, payload and a CRC-8
// (poly 0x07, init 0) over type, length and payload; one result per byte.
// ----------------------------------------------------------------------------
//  port group | dir | fields
//  req_*      | in  | tdata[7:0] data_byte
//  rsp_*      | out | tdata payload_byte/frame_type_out/frame_len_out,
//             |     | tuser status/payload_valid, tlast payload_last
//  csr_*      | in  | index 0 start_byte, index 1 max_payload_len
//
// One word a cycle while the sink keeps taking results: input register, then
// parser logic (byte-wide CRC step and state update) into the result register.
// Synchronous active-high reset: hunting, type/len/CRC zero, start byte 0xAA,
// max length 255. A stalled result register holds the input register; each
// stage still takes a new word in the cycle its current one leaves.
// ----------------------------------------------------------------------------
module crc8_frame_parser (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload_byte, [15:8] frame_type_out,
                                    // [23:16] frame_len_out
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] payload_valid
   output logic        rsp_tlast,   // payload_last
   // register writes
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import crc8fp_pkg::*;

   logic       advance;
   logic       hold_valid;
   logic [7:0] hold_byte;
   result_type result;

   crc8fp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   // parser state steps exactly when the held word enters the result register
   crc8fp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (hold_valid && advance),
      .data_byte (hold_byte),
      .result    (result)
   );

   crc8fp_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (hold_valid),
      .load_result (result),
      .advance     (advance),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );
endmodule

// ===== rtl/crc8fp_in_stage.sv =====
// ----------------------------------------------------------------------------
// crc8fp_in_stage: input register
// Holds one received word; takes a new one when empty or when the held word moves on.
// ----------------------------------------------------------------------------
module crc8fp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       advance,     // downstream takes the held word this cycle
   output logic       hold_valid,
   output logic [7:0] hold_byte
);
   import crc8fp_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         byte_ff <= req_tdata[ByteWidth-1:0];
      end
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;
endmodule

// ===== rtl/crc8fp_core.sv =====
// ----------------------------------------------------------------------------
// crc8fp_core: frame parser state and registers
// Next-state and result logic for one byte; state moves only when the byte
// is handed to the result register.
// ----------------------------------------------------------------------------
module crc8fp_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [7:0]              csr_wdata,
   input  logic                    step,
   input  logic [7:0]              data_byte,
   output crc8fp_pkg::result_type  result
);
   import crc8fp_pkg::*;

   logic [7:0] start_byte_ff, max_len_ff;
   state_type  state_ff, state_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] index_ff, index_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] crc_next;
   logic [7:0] index_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= 8'd170;
         max_len_ff    <= 8'd255;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_START_BYTE: start_byte_ff <= csr_wdata;
            CSR_MAX_LEN:    max_len_ff    <= csr_wdata;
            default:        start_byte_ff <= start_byte_ff;
         endcase
      end
   end

   // at the type byte the CRC restarts from its initial value
   assign crc_next  = crc8_update((state_ff == ST_TYPE) ? CrcInit : crc_ff, data_byte);
   assign index_inc = index_ff + 8'd1;

   always_comb begin
      state_in = ST_HUNT;
      type_in  = type_ff;
      len_in   = len_ff;
      index_in = index_ff;
      crc_in   = crc_ff;
      result.status        = STATUS_INCOMPLETE;
      result.payload_valid = 1'b0;
      result.payload_byte  = 8'h00;
      result.payload_last  = 1'b0;
      case (state_ff)
         ST_TYPE: begin
            type_in  = data_byte;
            crc_in   = crc_next;
            state_in = ST_LEN;
         end
         ST_LEN: begin
            if (data_byte > max_len_ff) begin
               result.status = STATUS_ERROR;
            end else begin
               len_in   = data_byte;
               index_in = 8'd0;
               crc_in   = crc_next;
               state_in = (data_byte != 8'd0) ? ST_PAYLOAD : ST_CRC;
            end
         end
         ST_PAYLOAD: begin
            crc_in   = crc_next;
            index_in = index_inc;
            result.payload_valid = 1'b1;
            result.payload_byte  = data_byte;
            if (index_inc >= len_ff) begin
               result.payload_last = 1'b1;
               state_in = ST_CRC;
            end else begin
               state_in = ST_PAYLOAD;
            end
         end
         ST_CRC: begin
            result.status = (data_byte == crc_ff) ? STATUS_COMPLETE : STATUS_ERROR;
         end
         default: begin
            if (data_byte == start_byte_ff) begin
               state_in = ST_TYPE;
            end
         end
      endcase
      result.frame_type = type_in;
      result.frame_len  = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         type_ff  <= 8'd0;
         len_ff   <= 8'd0;
         index_ff <= 8'd0;
         crc_ff   <= CrcInit;
      end else if (step) begin
         state_ff <= state_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         index_ff <= index_in;
         crc_ff   <= crc_in;
      end
   end
endmodule

// ===== rtl/crc8fp_out_stage.sv =====
// ----------------------------------------------------------------------------
// crc8fp_out_stage: result register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module crc8fp_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_valid,
   input  crc8fp_pkg::result_type  load_result,
   output logic                    advance,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [23:0]             rsp_tdata,  // [7:0] payload_byte, [15:8] frame_type_out,
                                               // [23:16] frame_len_out
   output logic [2:0]              rsp_tuser,  // [1:0] status, [2] payload_valid
   output logic                    rsp_tlast   // payload_last
);
   import crc8fp_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign advance  = !valid_ff || rsp_tready;
   assign valid_in = advance ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         result_ff <= load_result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {result_ff.frame_len, result_ff.frame_type, result_ff.payload_byte};
   assign rsp_tuser  = {result_ff.payload_valid, result_ff.status};
   assign rsp_tlast  = result_ff.payload_last;
endmodule

// ===== sim/tb_crc8_frame_parser.sv =====
// ----------------------------------------------------------------------------
// tb_crc8_frame_parser: self-checking bench for the CRC-8 frame parser
// Streams hunt noise and length-prefixed frames into the parser. A local
// parser model predicts one result word per accepted byte, and each result
// word is checked field by field. Covers zero and maximum lengths, oversize
// lengths, bad CRCs, start bytes inside frames, several register settings,
// random idling on both streams and a long result stall.
// ----------------------------------------------------------------------------
module tb_crc8_frame_parser;
   import crc8fp_pkg::*;

   localparam int PipeLatency = 2;          // input reg + result reg
   localparam int IdlePct     = 38;         // idle chance per cycle, both sides
   localparam int HoldCycles  = 48;         // long result stall

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;          // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;                  // [7:0] payload_byte, [15:8] frame_type,
                                            // [23:16] frame_len
   logic [2:0]  rsp_tuser;                  // [1:0] status, [2] payload_valid
   logic        rsp_tlast;                  // payload_last
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;

   crc8_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // --- parser model state; registers hold their reset values ---
   logic [7:0] cfg_start = 8'hAA;
   logic [7:0] cfg_max   = 8'hFF;
   state_type  psr_state = ST_HUNT;
   logic [7:0] psr_type  = 8'h00;
   logic [7:0] psr_len   = 8'h00;
   logic [7:0] psr_count = 8'h00;           // payload bytes seen so far
   logic [7:0] psr_crc   = 8'h00;

   result_type expected_q [$];              // one result word per accepted byte
   result_type want;
   int         failures   = 0;
   int         words_sent = 0;
   bit         no_idle    = 1'b0;           // both sides run flat out while set
   bit         hold_req   = 1'b0;           // one-cycle pulse starts a result stall
   int         hold_left  = 0;

   // CRC-8, poly 0x07, MSB first, one byte
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      repeat (8) r = r[7] ? ((r << 1) ^ CrcPoly) : (r << 1);
      return r;
   endfunction

   // advance the model by one received byte; returns the result word it causes
   function automatic result_type parse_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      case (psr_state)
         ST_TYPE: begin
            psr_type  = b;
            psr_crc   = crc8_step(CrcInit, b);
            psr_state = ST_LEN;
         end
         ST_LEN: begin
            if (b > cfg_max) begin
               // oversize: error, frame_len keeps the old value
               psr_state = ST_HUNT;
               r.status  = STATUS_ERROR;
            end else begin
               psr_len   = b;
               psr_count = 8'h00;
               psr_crc   = crc8_step(psr_crc, b);
               if (b != 8'h00) psr_state = ST_PAYLOAD;
               else psr_state = ST_CRC;   // zero length: CRC byte comes next
            end
         end
         ST_PAYLOAD: begin
            psr_crc         = crc8_step(psr_crc, b);
            psr_count       = psr_count + 8'd1;
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            if (psr_count >= psr_len) begin
               r.payload_last = 1'b1;
               psr_state      = ST_CRC;
            end
         end
         ST_CRC: begin
            psr_state = ST_HUNT;
            if (b == psr_crc) r.status = STATUS_COMPLETE;
            else r.status = STATUS_ERROR;
         end
         default: begin
            // hunting: only here is the start byte recognised
            if (b == cfg_start) psr_state = ST_TYPE;
            else psr_state = ST_HUNT;
         end
      endcase
      r.frame_type = psr_type;
      r.frame_len  = psr_len;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
         failures++;
      end
   endfunction

   // --- result side: random ready, plus a long counted stall on request ---
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         rsp_tready <= 1'b0;
         hold_left  <= HoldCycles - 1;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= IdlePct);
      end
   end

   // --- result checker: every accepted word against the oldest prediction ---
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("result word with nothing expected: tdata 0x%06h tuser 0x%0h",
                   rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = expected_q.pop_front();
            check_field("status",         8'(want.status),        8'(rsp_tuser[1:0]));
            check_field("payload_valid",  8'(want.payload_valid), 8'(rsp_tuser[2]));
            check_field("payload_byte",   want.payload_byte,      rsp_tdata[7:0]);
            check_field("payload_last",   8'(want.payload_last),  8'(rsp_tlast));
            check_field("frame_type_out", want.frame_type,        rsp_tdata[15:8]);
            check_field("frame_len_out",  want.frame_len,         rsp_tdata[23:16]);
         end
      end
   end

   // one byte into the parser; the prediction is made at the accepting edge.
   // valid is left high on return so back-to-back words never drop it.
   task automatic send_byte(input logic [7:0] b);
      while (!no_idle && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(parse_byte(b));
      words_sent++;
   endtask

   // sender stops until every predicted word is out and the pipe is empty
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (PipeLatency + 2) @(posedge clock);
   endtask

   // register write, only with the parser idle
   task automatic csr_write(input csr_index_type idx, input logic [7:0] value);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_START_BYTE) cfg_start = value;
      else cfg_max = value;
   endtask

   // whole frame: start, type, length, payload, CRC. An oversize length ends
   // the frame after the length byte, as the parser drops back to hunting.
   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                             input bit inject_start, input bit corrupt);
      logic [7:0] crc;
      logic [7:0] b;
      int         i;
      send_byte(cfg_start);
      send_byte(ftype);
      send_byte(flen);
      if (flen > cfg_max) return;
      crc = crc8_step(crc8_step(CrcInit, ftype), flen);
      for (i = 0; i < flen; i++) begin
         b = 8'($urandom_range(255));
         // start byte as data, must not restart the frame
         if ((inject_start && i == 0) || $urandom_range(15) == 0) b = cfg_start;
         crc = crc8_step(crc, b);
         send_byte(b);
      end
      if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
      send_byte(crc);
   endtask

   // noise byte that cannot open a frame
   task automatic send_noise();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == cfg_start) b = b ^ 8'h01;
      send_byte(b);
   endtask

   // --- tests ---

   // noise, then a zero-length frame with extreme type byte
   task automatic test_basic_frames();
      send_byte(8'h00);
      send_frame(8'hFF, 8'd0, 1'b0, 1'b0);
   endtask

   // start byte inside the payload is plain data
   task automatic test_start_in_payload();
      send_frame(8'h00, 8'd2, 1'b1, 1'b0);
   endtask

   task automatic test_crc_mismatch();
      send_frame(8'h01, 8'd1, 1'b0, 1'b1);
   endtask

   // max length 0: any payload is oversize, zero length still passes
   task automatic test_length_limit();
      csr_write(CSR_MAX_LEN, 8'h00);
      send_frame(8'h05, 8'd1, 1'b0, 1'b0);
      send_frame(8'h5A, 8'd0, 1'b0, 1'b0);
      drain_results();
   endtask

   // long result stall while the sender keeps offering: parser fills and
   // pushes back on the input side; then the sender waits for the backlog
   task automatic test_backpressure();
      csr_write(CSR_MAX_LEN, 8'hFF);
      no_idle  = 1'b1;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      send_frame(8'($urandom_range(255)), 8'd20, 1'b0, 1'b0);
      drain_results();
      no_idle = 1'b0;
   endtask

   // mostly well-formed frames over several register settings; the first frame
   // of each phase has the largest length allowed there
   task automatic test_random_traffic(input int target_words);
      logic [7:0] s;
      logic [7:0] m;
      logic [7:0] flen;
      int         p;
      int         pick;
      int         phase_end;
      int         per_phase;
      per_phase = (target_words - words_sent) / 4;
      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin s = 8'hAA; m = 8'hFF; end
            1: begin s = 8'h00; m = 8'h00; end
            2: begin s = 8'hFF; m = 8'd12; end
            default: begin
               s = 8'($urandom_range(1, 254));
               m = 8'($urandom_range(4, 40));
            end
         endcase
         csr_write(CSR_START_BYTE, s);
         csr_write(CSR_MAX_LEN, m);
         no_idle   = (p == 2);             // long stretch with no idling
         phase_end = (p == 3) ? target_words : words_sent + per_phase;
         send_frame(8'($urandom_range(255)), m, 1'b0, 1'b0);
         while (words_sent < phase_end) begin
            pick = $urandom_range(99);
            if (m == 8'h00) flen = 8'h00;
            else if ($urandom_range(9) == 0) flen = 8'($urandom_range(0, m));
            else flen = 8'($urandom_range(0, (m < 10) ? m : 10));
            if (pick < 8) begin
               repeat ($urandom_range(1, 4)) send_noise();
            end else if (pick < 18) begin
               send_frame(8'($urandom_range(255)), flen, $urandom_range(3) == 0, 1'b1);
            end else if (pick < 28 && m != 8'hFF) begin
               send_frame(8'($urandom_range(255)), 8'($urandom_range(m + 1, 255)),
                          1'b0, 1'b0);
            end else begin
               send_frame(8'($urandom_range(255)), flen, $urandom_range(3) == 0, 1'b0);
            end
            // now and then let the whole backlog clear before going on
            if ($urandom_range(19) == 0) drain_results();
         end
         drain_results();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_frames();
      test_start_in_payload();
      test_crc_mismatch();
      test_length_limit();
      test_backpressure();
      test_random_traffic(950);
      drain_results();
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
